// File: rtl/ilqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilqm_pkg
// Shared types and constants of the indexed linked queue manager.
// ----------------------------------------------------------------------------
package ilqm_pkg;

  localparam int SLOTS   = 256;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LINK_W  = SLOT_W + 1;
  localparam int COUNT_W = 9;
  localparam int OP_W    = 2;

  // link value that marks the end of the list
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;   // input transfer: latch item, issue link reads
    logic exec;   // evaluate item, first link writes, load result
    logic wr2;    // second link writes
  } ilqm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } ilqm_sts_t;

endpackage

// File: rtl/ilqm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilqm_in_if
// Request channel: operation and slot with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ilqm_in_if;
  logic                          valid;
  logic                          ready;
  logic [ilqm_pkg::OP_W-1:0]     operation;
  logic [7:0]                    slot;

  modport source (output valid, output operation, output slot, input ready);
  modport sink   (input valid, input operation, input slot, output ready);
endinterface

// File: rtl/ilqm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilqm_out_if
// Result channel: outcome, popped slot, head and count with valid/ready.
// ----------------------------------------------------------------------------
interface ilqm_out_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [7:0]                     popped_slot;
  logic                           popped_valid;
  logic [7:0]                     head_slot;
  logic                           head_valid;
  logic [ilqm_pkg::COUNT_W-1:0]   element_count;

  modport source (output valid, output ok, output popped_slot, output popped_valid,
                  output head_slot, output head_valid, output element_count,
                  input ready);
  modport sink   (input valid, input ok, input popped_slot, input popped_valid,
                  input head_slot, input head_valid, input element_count,
                  output ready);
endinterface

// File: rtl/ilqm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilqm_ctrl
// Sequencer: accept, evaluate, second writeback (overlapped with next accept).
// ----------------------------------------------------------------------------
module ilqm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ilqm_pkg::ilqm_sts_t sts,
  output ilqm_pkg::ilqm_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WR2  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  // ready whenever the link memories have a free read slot
  assign in_ready = (state_r == ST_IDLE) || (state_r == ST_WR2);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.load  = accept;
    cmd.exec  = 1'b0;
    cmd.wr2   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_WR2;
        end
      end
      ST_WR2: begin
        cmd.wr2   = 1'b1;
        state_nxt = accept ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/ilqm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilqm_dp
// Link memories, head/tail/count registers, list update logic, result register.
// ----------------------------------------------------------------------------
module ilqm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ilqm_pkg::ilqm_cmd_t           cmd,
  output ilqm_pkg::ilqm_sts_t           sts,
  input  logic [ilqm_pkg::OP_W-1:0]     in_operation,
  input  logic [7:0]                    in_slot,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [7:0]                    out_popped_slot,
  output logic                          out_popped_valid,
  output logic [7:0]                    out_head_slot,
  output logic                          out_head_valid,
  output logic [ilqm_pkg::COUNT_W-1:0]  out_element_count
);

  localparam int SW = ilqm_pkg::SLOT_W;
  localparam int LW = ilqm_pkg::LINK_W;
  localparam int CW = ilqm_pkg::COUNT_W;

  // link memories
  logic [LW-1:0] tt_mem [ilqm_pkg::SLOTS];
  logic [LW-1:0] th_mem [ilqm_pkg::SLOTS];
  logic [LW-1:0] tt_q;
  logic [LW-1:0] th_q;

  // latched item
  logic [ilqm_pkg::OP_W-1:0] op_r;
  logic [SW-1:0]             slot_r;

  // list registers
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // deferred second writes
  logic          w2t_en_r, w2h_en_r;
  logic [SW-1:0] w2t_addr_r, w2h_addr_r;
  logic [LW-1:0] w2t_data_r, w2h_data_r;

  // bypass of a second write hitting the overlapped read
  logic          tt_hit_r, th_hit_r;
  logic [LW-1:0] tt_byp_r, th_byp_r;

  // result register
  logic          out_valid_r;
  logic          ok_r, pv_r, hv_r;
  logic [7:0]    pop_r, hs_r;
  logic [CW-1:0] cnt_out_r;

  logic [SW-1:0] rd_addr;
  logic [SW-1:0] slot_in;
  logic [LW-1:0] tt_rd, th_rd;
  logic [LW-1:0] s9;
  logic          empty, single;
  logic          ok_c, pv_c;
  logic [SW-1:0] pop_c;

  // first and second write requests, 9-bit addresses (null means skip)
  logic          w1t_en, w1h_en, w2t_en, w2h_en;
  logic [LW-1:0] w1t_a, w1h_a, w2t_a, w2h_a;
  logic [LW-1:0] w1t_d, w1h_d, w2t_d, w2h_d;

  // memory port muxes
  logic          tt_we, th_we;
  logic [SW-1:0] tt_wa, th_wa;
  logic [LW-1:0] tt_wd, th_wd;

  assign slot_in = SW'(in_slot);
  // dequeue follows the head, remove looks at the named slot
  assign rd_addr = (in_operation == ilqm_pkg::OP_DEQUEUE) ? head_r[SW-1:0] : slot_in;

  assign tt_rd = tt_hit_r ? tt_byp_r : tt_q;
  assign th_rd = th_hit_r ? th_byp_r : th_q;

  assign sts.out_free = !out_valid_r || out_ready;

  // list update for the latched item
  always_comb begin
    s9        = {1'b0, slot_r};
    empty     = head_r[LW-1] || tail_r[LW-1];
    single    = (head_r == tail_r);
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ok_c      = 1'b0;
    pv_c      = 1'b0;
    pop_c     = '0;
    w1t_en = 1'b0; w1t_a = ilqm_pkg::NULL_LINK; w1t_d = ilqm_pkg::NULL_LINK;
    w1h_en = 1'b0; w1h_a = ilqm_pkg::NULL_LINK; w1h_d = ilqm_pkg::NULL_LINK;
    w2t_en = 1'b0; w2t_a = ilqm_pkg::NULL_LINK; w2t_d = ilqm_pkg::NULL_LINK;
    w2h_en = 1'b0; w2h_a = ilqm_pkg::NULL_LINK; w2h_d = ilqm_pkg::NULL_LINK;
    case (op_r)
      ilqm_pkg::OP_ENQUEUE: begin
        ok_c      = 1'b1;
        count_nxt = count_r + CW'(1);
        if (tail_r[LW-1]) begin
          head_nxt = s9;
          tail_nxt = s9;
          w1t_en = 1'b1; w1t_a = s9;
          w1h_en = 1'b1; w1h_a = s9;
        end else begin
          w1h_en = 1'b1; w1h_a = s9;     w1h_d = tail_r;
          w1t_en = 1'b1; w1t_a = s9;
          w2t_en = 1'b1; w2t_a = tail_r; w2t_d = s9;
          tail_nxt = s9;
        end
      end
      ilqm_pkg::OP_DEQUEUE: begin
        if (!empty) begin
          ok_c      = 1'b1;
          pv_c      = 1'b1;
          pop_c     = head_r[SW-1:0];
          count_nxt = count_r - CW'(1);
          w1t_en = 1'b1; w1t_a = head_r;
          if (single) begin
            head_nxt = ilqm_pkg::NULL_LINK;
            tail_nxt = ilqm_pkg::NULL_LINK;
            w1h_en = 1'b1; w1h_a = head_r;
          end else begin
            head_nxt = tt_rd;
            w1h_en = 1'b1; w1h_a = tt_rd;
            w2h_en = 1'b1; w2h_a = head_r;
          end
        end
      end
      ilqm_pkg::OP_REMOVE: begin
        if (!empty) begin
          ok_c      = 1'b1;
          count_nxt = count_r - CW'(1);
          if (single) begin
            head_nxt = ilqm_pkg::NULL_LINK;
            tail_nxt = ilqm_pkg::NULL_LINK;
            w1t_en = 1'b1; w1t_a = s9;
            w1h_en = 1'b1; w1h_a = s9;
          end else if (s9 == tail_r) begin
            // unlink the tail
            w1t_en = 1'b1; w1t_a = th_rd; w1t_d = tt_rd;
            w2t_en = 1'b1; w2t_a = s9;
            w1h_en = 1'b1; w1h_a = s9;
            tail_nxt = th_rd;
          end else if (s9 == head_r) begin
            // unlink the head
            w1h_en = 1'b1; w1h_a = tt_rd; w1h_d = th_rd;
            w2h_en = 1'b1; w2h_a = s9;
            w1t_en = 1'b1; w1t_a = s9;
            head_nxt = tt_rd;
          end else begin
            // unlink from the middle
            w1h_en = 1'b1; w1h_a = tt_rd; w1h_d = th_rd;
            w1t_en = 1'b1; w1t_a = th_rd; w1t_d = tt_rd;
            w2t_en = 1'b1; w2t_a = s9;
            w2h_en = 1'b1; w2h_a = s9;
          end
        end
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  // write port select: first writes on evaluate, deferred ones after
  always_comb begin
    if (cmd.exec) begin
      tt_we = w1t_en && !w1t_a[LW-1];
      tt_wa = w1t_a[SW-1:0];
      tt_wd = w1t_d;
      th_we = w1h_en && !w1h_a[LW-1];
      th_wa = w1h_a[SW-1:0];
      th_wd = w1h_d;
    end else begin
      tt_we = cmd.wr2 && w2t_en_r;
      tt_wa = w2t_addr_r;
      tt_wd = w2t_data_r;
      th_we = cmd.wr2 && w2h_en_r;
      th_wa = w2h_addr_r;
      th_wd = w2h_data_r;
    end
  end

  // link memories, registered read on input transfer
  always_ff @(posedge clk) begin
    if (tt_we) tt_mem[tt_wa] <= tt_wd;
    if (th_we) th_mem[th_wa] <= th_wd;
    if (cmd.load) begin
      tt_q <= tt_mem[rd_addr];
      th_q <= th_mem[rd_addr];
    end
  end

  // item latch, bypass data and deferred write payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      slot_r   <= slot_in;
      tt_byp_r <= w2t_data_r;
      th_byp_r <= w2h_data_r;
    end
    if (cmd.exec) begin
      w2t_addr_r <= w2t_a[SW-1:0];
      w2t_data_r <= w2t_d;
      w2h_addr_r <= w2h_a[SW-1:0];
      w2h_data_r <= w2h_d;
      ok_r       <= ok_c;
      pv_r       <= pv_c;
      pop_r      <= 8'(pop_c);
      hv_r       <= !head_nxt[LW-1];
      hs_r       <= head_nxt[LW-1] ? 8'd0 : 8'(head_nxt[SW-1:0]);
      cnt_out_r  <= count_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= ilqm_pkg::NULL_LINK;
      tail_r      <= ilqm_pkg::NULL_LINK;
      count_r     <= '0;
      w2t_en_r    <= 1'b0;
      w2h_en_r    <= 1'b0;
      tt_hit_r    <= 1'b0;
      th_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        count_r  <= count_nxt;
        w2t_en_r <= w2t_en && !w2t_a[LW-1];
        w2h_en_r <= w2h_en && !w2h_a[LW-1];
      end
      // a read overlapping the deferred write takes the new value
      if (cmd.load) begin
        tt_hit_r <= cmd.wr2 && w2t_en_r && (w2t_addr_r == rd_addr);
        th_hit_r <= cmd.wr2 && w2h_en_r && (w2h_addr_r == rd_addr);
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = ok_r;
  assign out_popped_slot   = pop_r;
  assign out_popped_valid  = pv_r;
  assign out_head_slot     = hs_r;
  assign out_head_valid    = hv_r;
  assign out_element_count = cnt_out_r;

endmodule

// File: rtl/indexed_linked_queue_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_linked_queue_manager_top
// Slot FIFO kept as a doubly linked list in two link memories.
// ----------------------------------------------------------------------------
// Timing: the input transfer latches the item, and the result register loads
//   when the item is evaluated; a held result stalls the evaluate state.
// Overlap: each link memory has a single write port, so an item takes a read,
//   a first writeback and a second writeback, the second overlapped with the
//   next item's read; a held result keeps the next item waiting in evaluate.
// Reset: synchronous, active low; empties the queue and clears the count.
//   Link memory contents are undefined until written.
module indexed_linked_queue_manager_top (
  input  logic        clk,
  input  logic        rst_n,
  ilqm_in_if.sink     in_ch,
  ilqm_out_if.source  out_ch
);

  ilqm_pkg::ilqm_cmd_t cmd;
  ilqm_pkg::ilqm_sts_t sts;

  // sequencer
  ilqm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // link memories and list registers
  ilqm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_ch.operation),
    .in_slot           (in_ch.slot),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ok            (out_ch.ok),
    .out_popped_slot   (out_ch.popped_slot),
    .out_popped_valid  (out_ch.popped_valid),
    .out_head_slot     (out_ch.head_slot),
    .out_head_valid    (out_ch.head_valid),
    .out_element_count (out_ch.element_count)
  );

endmodule
